### hw/rtl/lsch_pkg.sv
// Shared types and constants for the lottery scheduler unit.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package lsch_pkg;

    // Fixed field widths of the command and result beats
    localparam int IDX_IN_W    = 4;
    localparam int TICKET_IN_W = 16;
    localparam int STATE_W     = 2;
    localparam int RND_W       = 32;
    localparam int IDX_OUT_W   = 4;
    localparam int TOTAL_W     = 20;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Entry state codes
    localparam logic [STATE_W-1:0] ST_OTHER   = 2'd0;
    localparam logic [STATE_W-1:0] ST_READY   = 2'd1;
    localparam logic [STATE_W-1:0] ST_CURRENT = 2'd2;

    // Command modes
    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_RESCHED = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SUM      = 6'b000010,
        S_MOD_WAIT = 6'b000100,
        S_WALK     = 6'b001000,
        S_WR_WIN   = 6'b010000,
        S_WR_PREV  = 6'b100000
    } fsm_t;

endpackage

### hw/rtl/lsch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lsch_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lsch_mod.sv
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// No dependencies; used by the lottery scheduler top level.
`timescale 1ns / 1ps

module lsch_mod #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;

    // Shift in the next dividend bit; subtract when it fits
    assign shifted = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(DIVIDEND_W);
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            rem_next = diff[DIVISOR_W] ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### hw/rtl/lottery_scheduler_unit.sv
// Lottery scheduler top level: entry table, sequencer, shared accumulator.
// Depends on lsch_pkg, lsch_ram and lsch_mod.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             mode, proc_index, ticket_count,
//                                                entry_state, random_value
// result    out        done (one-cycle strobe)   chosen_index, found, total_tickets
//
// A write beat gives no result and keeps busy low. A reschedule beat holds busy
// high through the sum pass, which reads every table entry and totals the ready
// tickets, the bit-serial modulo unit, the walk pass, which reads the table
// again to find the winner, and one table write, with a second one when the old
// current entry is handed back. A zero ready total ends after the sum pass. The
// result strobe follows in the first idle cycle.
// Reset clears the sequencer state, counters, flags, the current index and the
// per-entry valid bits; an entry that was never written reads as zero tickets,
// state other. The receiver cannot stall: each result beat is on the ports for
// exactly one cycle.

module lottery_scheduler_unit
    import lsch_pkg::*;
#(
    parameter int NUM_PROCS    = 16,
    parameter int TICKET_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   mode,
    input  logic [IDX_IN_W-1:0]    proc_index,
    input  logic [TICKET_IN_W-1:0] ticket_count,
    input  logic [STATE_W-1:0]     entry_state,
    input  logic [RND_W-1:0]       random_value,
    output logic                   done,
    output logic [IDX_OUT_W-1:0]   chosen_index,
    output logic                   found,
    output logic [TOTAL_W-1:0]     total_tickets
);

    localparam int IDX_W = $clog2(NUM_PROCS);
    localparam int CNT_W = IDX_W + 1;
    localparam int SUM_W = TICKET_WIDTH + IDX_W;
    localparam int ENT_W = TICKET_WIDTH + STATE_W;

    // Sequencer and pass control
    fsm_t                    state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    ent_vld_reg;
    logic [NUM_PROCS-1:0]    valid_reg, valid_next;
    logic [IDX_W-1:0]        current_reg, current_next;
    logic                    was_cur_reg, was_cur_next;
    logic                    hit_reg, hit_next;
    // Old current index, held for the hand-back write
    logic [IDX_W-1:0]        prev_idx_reg;

    // Datapath registers
    logic [SUM_W-1:0]        acc_reg, acc_next;
    logic [SUM_W-1:0]        total_reg, total_next;
    logic [RND_W-1:0]        rnd_reg, rnd_next;
    logic [SUM_W-1:0]        winning_reg, winning_next;
    logic [IDX_W-1:0]        win_idx_reg, win_idx_next;
    logic [TICKET_WIDTH-1:0] win_tkt_reg, win_tkt_next;
    logic [TICKET_WIDTH-1:0] prev_tkt_reg, prev_tkt_next;

    // Result beat
    logic                    done_reg, done_next;
    logic [IDX_OUT_W-1:0]    chosen_reg, chosen_next;
    logic                    found_reg, found_next;
    logic [TOTAL_W-1:0]      tot_out_reg, tot_out_next;

    // Table port
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENT_W-1:0]        ram_rdata;

    // Modulo unit
    logic                    mod_start;
    logic                    mod_done;
    logic [SUM_W-1:0]        mod_rem;

    // Entry as seen by the passes
    logic [STATE_W-1:0]      ent_state;
    logic [TICKET_WIDTH-1:0] ent_tkt;
    logic                    ent_is_cur;
    logic                    ent_ready;
    logic [SUM_W-1:0]        add_sum;
    logic                    accept;
    logic                    wr_in_range;
    logic                    pass_last;
    logic [TOTAL_W-1:0]      total_sat;

    assign accept      = start && (state_reg == S_IDLE);
    assign wr_in_range = (32'(proc_index) < 32'(NUM_PROCS));

    // Unwritten entries read as zero tickets, state other
    assign ent_state  = ent_vld_reg ? ram_rdata[ENT_W-1 -: STATE_W] : ST_OTHER;
    assign ent_tkt    = ent_vld_reg ? ram_rdata[TICKET_WIDTH-1:0] : '0;
    // The current entry counts as ready during the draw
    assign ent_is_cur = (rd_idx_reg == current_reg) && (ent_state == ST_CURRENT);
    assign ent_ready  = rd_vld_reg && ((ent_state == ST_READY) || ent_is_cur);

    // Shared accumulator adder for both passes
    assign add_sum = acc_reg + SUM_W'(ent_tkt);

    // The last read of a pass is processed when the counter has reached the depth
    assign pass_last = (cnt_reg == CNT_W'(NUM_PROCS));

    assign total_sat = (64'(total_reg) > 64'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(total_reg);

    assign ram_raddr = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = 1'b0;
        valid_next    = valid_reg;
        current_next  = current_reg;
        was_cur_next  = was_cur_reg;
        hit_next      = hit_reg;
        acc_next      = acc_reg;
        total_next    = total_reg;
        rnd_next      = rnd_reg;
        winning_next  = winning_reg;
        win_idx_next  = win_idx_reg;
        win_tkt_next  = win_tkt_reg;
        prev_tkt_next = prev_tkt_reg;
        done_next     = 1'b0;
        chosen_next   = chosen_reg;
        found_next    = found_reg;
        tot_out_next  = tot_out_reg;
        ram_we        = 1'b0;
        ram_waddr     = IDX_W'(proc_index);
        ram_wdata     = {entry_state, TICKET_WIDTH'(ticket_count)};
        mod_start     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (mode == MODE_WRITE))
                begin
                    // Drop writes beyond the table
                    if (wr_in_range)
                    begin
                        ram_we = 1'b1;
                        valid_next[IDX_W'(proc_index)] = 1'b1;
                    end
                end
                else if (accept)
                begin
                    rnd_next     = random_value;
                    acc_next     = '0;
                    cnt_next     = '0;
                    was_cur_next = 1'b0;
                    state_next   = S_SUM;
                end
            end

            S_SUM:
            begin
                rd_vld_next = !pass_last;
                if (!pass_last)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (ent_ready)
                begin
                    acc_next = add_sum;
                end
                if (rd_vld_reg && ent_is_cur)
                begin
                    was_cur_next  = 1'b1;
                    prev_tkt_next = ent_tkt;
                end
                if (pass_last)
                begin
                    total_next = acc_next;
                    if (acc_next == '0)
                    begin
                        // No tickets: keep the current entry, flag no winner
                        done_next    = 1'b1;
                        chosen_next  = IDX_OUT_W'(current_reg);
                        found_next   = 1'b0;
                        tot_out_next = '0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD_WAIT;
                    end
                end
            end

            S_MOD_WAIT:
            begin
                if (mod_done)
                begin
                    winning_next = mod_rem;
                    acc_next     = '0;
                    cnt_next     = '0;
                    hit_next     = 1'b0;
                    win_idx_next = IDX_W'(NUM_PROCS - 1);
                    win_tkt_next = '0;
                    state_next   = S_WALK;
                end
            end

            S_WALK:
            begin
                rd_vld_next = !pass_last;
                if (!pass_last)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (ent_ready)
                begin
                    acc_next = add_sum;
                    if (!hit_reg && (add_sum > winning_reg))
                    begin
                        hit_next     = 1'b1;
                        win_idx_next = rd_idx_reg;
                        win_tkt_next = ent_tkt;
                    end
                end
                if (pass_last)
                begin
                    state_next = S_WR_WIN;
                end
            end

            S_WR_WIN:
            begin
                ram_we       = 1'b1;
                ram_waddr    = win_idx_reg;
                ram_wdata    = {ST_CURRENT, win_tkt_reg};
                valid_next[win_idx_reg] = 1'b1;
                current_next = win_idx_reg;
                if (was_cur_reg && (win_idx_reg != current_reg))
                begin
                    state_next = S_WR_PREV;
                end
                else
                begin
                    done_next    = 1'b1;
                    chosen_next  = IDX_OUT_W'(win_idx_reg);
                    found_next   = 1'b1;
                    tot_out_next = total_sat;
                    state_next   = S_IDLE;
                end
            end

            S_WR_PREV:
            begin
                // Hand the old current entry back to ready; current_reg already
                // holds the winner, so the old index is taken from the beat state
                ram_we       = 1'b1;
                ram_waddr    = prev_idx_reg;
                ram_wdata    = {ST_READY, prev_tkt_reg};
                done_next    = 1'b1;
                chosen_next  = IDX_OUT_W'(win_idx_reg);
                found_next   = 1'b1;
                tot_out_next = total_sat;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR_WIN)
        begin
            prev_idx_reg <= current_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            valid_reg   <= '0;
            current_reg <= '0;
            was_cur_reg <= 1'b0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            valid_reg   <= valid_next;
            current_reg <= current_next;
            was_cur_reg <= was_cur_next;
            hit_reg     <= hit_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= ram_raddr;
        ent_vld_reg  <= valid_reg[ram_raddr];
        acc_reg      <= acc_next;
        total_reg    <= total_next;
        rnd_reg      <= rnd_next;
        winning_reg  <= winning_next;
        win_idx_reg  <= win_idx_next;
        win_tkt_reg  <= win_tkt_next;
        prev_tkt_reg <= prev_tkt_next;
        chosen_reg   <= chosen_next;
        found_reg    <= found_next;
        tot_out_reg  <= tot_out_next;
    end

    lsch_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_PROCS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lsch_mod #(
        .DIVIDEND_W (RND_W),
        .DIVISOR_W  (SUM_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (rnd_reg),
        .divisor   (acc_next),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign chosen_index  = chosen_reg;
    assign found         = found_reg;
    assign total_tickets = tot_out_reg;

endmodule

### tb/tb_lottery_scheduler_unit.sv
// Self-checking testbench for lottery_scheduler_unit: directed and random command beats,
// with every draw checked against a cycle-free mirror of the entry table.
// Depends on lsch_pkg and the lottery_scheduler_unit RTL.
`timescale 1ns / 1ps

module tb_lottery_scheduler_unit;
    import lsch_pkg::*;

    localparam int NPROC       = 16;
    localparam int PHASE_BEATS = 420;   // random command beats per pacing phase
    localparam int TAIL_CYCLES = 150;   // about twice the longest reschedule
    localparam int STALL_LIMIT = 3000;  // cycles without any beat before giving up
    localparam int SHOW_MAX    = 10;

    // Unnamed fourth entry state: stored as written, acts as other
    localparam logic [STATE_W-1:0] ST_SPARE = 2'd3;

    // One command beat as the sender queues it
    typedef struct {
        logic                   mode;
        logic [IDX_IN_W-1:0]    idx;
        logic [TICKET_IN_W-1:0] tickets;
        logic [STATE_W-1:0]     est;
        logic [RND_W-1:0]       rnd;
    } sched_cmd_t;

    // One expected result beat
    typedef struct {
        logic [IDX_OUT_W-1:0] idx;
        logic                 hit;
        logic [TOTAL_W-1:0]   total;
    } draw_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic mode = MODE_WRITE;
    logic [IDX_IN_W-1:0] proc_index = '0;
    logic [TICKET_IN_W-1:0] ticket_count = '0;
    logic [STATE_W-1:0] entry_state = ST_OTHER;
    logic [RND_W-1:0] random_value = '0;
    logic done;
    logic [IDX_OUT_W-1:0] chosen_index;
    logic found;
    logic [TOTAL_W-1:0] total_tickets;

    sched_cmd_t cmd_q[$];   // beats waiting to be driven
    draw_t      draw_q[$];  // draws predicted but not yet seen

    // Mirror of the entry table and the current entry
    logic [TICKET_IN_W-1:0] tix_tbl [NPROC];
    logic [STATE_W-1:0]     st_tbl  [NPROC];
    logic [IDX_OUT_W-1:0]   cur_ent;

    int unsigned idle_pct = 0;
    int unsigned n_beats = 0;
    int unsigned n_draws = 0;
    int unsigned n_nowin = 0;
    int unsigned n_err = 0;
    int unsigned idle_cycles = 0;
    sched_cmd_t  nxt;
    draw_t       want;

    lottery_scheduler_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .proc_index    (proc_index),
        .ticket_count  (ticket_count),
        .entry_state   (entry_state),
        .random_value  (random_value),
        .done          (done),
        .chosen_index  (chosen_index),
        .found         (found),
        .total_tickets (total_tickets)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Update the table mirror with one accepted beat; a reschedule also
    // predicts the draw it must produce and queues it.
    task automatic apply_command(input logic m, input logic [IDX_IN_W-1:0] idx,
                                 input logic [TICKET_IN_W-1:0] tk,
                                 input logic [STATE_W-1:0] es, input logic [RND_W-1:0] rv);
        draw_t       d;
        logic [63:0] sum;
        logic [63:0] win;
        logic [63:0] acc;
        logic        was_cur;
        logic        hit;
        logic [IDX_OUT_W-1:0] prev;
        int unsigned pick;
        sum = '0;
        acc = '0;
        hit = 1'b0;
        was_cur = 1'b0;
        pick = NPROC - 1;
        if (m == MODE_WRITE)
        begin
            // every 4-bit index is in range at 16 entries
            tix_tbl[idx] = tk;
            st_tbl[idx] = es;
            return;
        end
        prev = cur_ent;
        // Hand the running entry back to the pool; state three is left alone
        if (st_tbl[prev] == ST_CURRENT)
        begin
            st_tbl[prev] = ST_READY;
            was_cur = 1'b1;
        end
        for (int k = 0; k < NPROC; k++)
            if (st_tbl[k] == ST_READY)
                sum += 64'(tix_tbl[k]);
        n_draws++;
        if (sum == 0)
        begin
            // No tickets in play: no winner, the previous entry keeps running
            if (was_cur)
                st_tbl[prev] = ST_CURRENT;
            d.idx = prev;
            d.hit = 1'b0;
            d.total = '0;
            n_nowin++;
        end
        else
        begin
            win = {32'd0, rv} % sum;
            for (int k = 0; k < NPROC; k++)
            begin
                if (!hit && st_tbl[k] == ST_READY)
                begin
                    acc += 64'(tix_tbl[k]);
                    if (acc > win)
                    begin
                        pick = k;
                        hit = 1'b1;
                    end
                end
            end
            cur_ent = pick[IDX_OUT_W-1:0];
            st_tbl[pick] = ST_CURRENT;
            d.idx = pick[IDX_OUT_W-1:0];
            d.hit = 1'b1;
            d.total = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
        draw_q.push_back(d);
    endtask

    function automatic void push_wr(input logic [IDX_IN_W-1:0] idx,
                                    input logic [TICKET_IN_W-1:0] tk,
                                    input logic [STATE_W-1:0] es);
        sched_cmd_t c;
        c.mode = MODE_WRITE;
        c.idx = idx;
        c.tickets = tk;
        c.est = es;
        c.rnd = $urandom;
        cmd_q.push_back(c);
    endfunction

    function automatic void push_rs(input logic [RND_W-1:0] rv);
        sched_cmd_t c;
        c.mode = MODE_RESCHED;
        c.idx = IDX_IN_W'($urandom);
        c.tickets = TICKET_IN_W'($urandom);
        c.est = STATE_W'($urandom);
        c.rnd = rv;
        cmd_q.push_back(c);
    endfunction

    function automatic logic [TICKET_IN_W-1:0] rand_tickets();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 50)
            return TICKET_IN_W'($urandom_range(1, 15));
        else if (r < 70)
            return TICKET_IN_W'($urandom_range(16, 255));
        else
            return TICKET_IN_W'($urandom);
    endfunction

    function automatic logic [STATE_W-1:0] rand_state();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return ST_READY;
        else if (r < 75)
            return ST_OTHER;
        else if (r < 90)
            return ST_CURRENT;
        else
            return ST_SPARE;
    endfunction

    function automatic logic [RND_W-1:0] rand_draw();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 15)
            return '1;
        else if (r < 20)
            return $urandom_range(0, 100);
        else
            return $urandom;
    endfunction

    // Hold until the sender has nothing left and every draw has come back.
    // Sample at the falling edge so the state is settled.
    task automatic drain();
        do
            @(negedge clk);
        while (cmd_q.size() != 0 || start || busy || draw_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Driver: a beat is taken at an edge where start is high and busy low.
    // Hold the beat while busy, otherwise load the next one or idle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_command(mode, proc_index, ticket_count, entry_state, random_value);
                n_beats++;
            end
            if (!start || !busy)
            begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    nxt = cmd_q.pop_front();
                    mode <= nxt.mode;
                    proc_index <= nxt.idx;
                    ticket_count <= nxt.tickets;
                    entry_state <= nxt.est;
                    random_value <= nxt.rnd;
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done strobe is one result beat; check it against the
    // oldest predicted draw. The receiver has no way to stall.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (draw_q.size() == 0)
            begin
                n_err++;
                if (n_err <= SHOW_MAX)
                    $display("unexpected result beat: idx %0d found %0b total %0d",
                             chosen_index, found, total_tickets);
            end
            else
            begin
                want = draw_q.pop_front();
                if (chosen_index !== want.idx || found !== want.hit
                        || total_tickets !== want.total)
                begin
                    n_err++;
                    if (n_err <= SHOW_MAX)
                        $display({"draw mismatch: exp idx %0d found %0b total %0d, ",
                                  "got idx %0d found %0b total %0d"},
                                 want.idx, want.hit, want.total,
                                 chosen_index, found, total_tickets);
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no beat in either direction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("lottery_scheduler_unit test failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned pace [4];
        int unsigned cnt;
        int unsigned r;
        // Phase pacing: back to back, sparse sender, back to back again
        // (the receiver side has no stall to exercise), moderately sparse.
        pace[0] = 0;
        pace[1] = 45;
        pace[2] = 0;
        pace[3] = 35;
        for (int k = 0; k < NPROC; k++)
        begin
            tix_tbl[k] = '0;
            st_tbl[k] = ST_OTHER;
        end
        cur_ent = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: draw from an empty table, extreme tickets, a zero-ticket
        // ready entry, state three, a stray current entry, edge draws
        push_rs('0);
        push_wr(4'd0, 16'hFFFF, ST_READY);
        push_wr(4'd15, 16'd1, ST_READY);
        push_wr(4'd5, 16'd0, ST_READY);
        push_wr(4'd3, 16'd100, ST_SPARE);
        push_wr(4'd7, 16'd50, ST_CURRENT);
        push_rs('0);
        push_rs('1);
        push_rs(32'h0000FFFF);
        // Current entry holds no tickets and no other ready entry holds any
        push_wr(4'd0, 16'd0, ST_OTHER);
        push_wr(4'd15, 16'd0, ST_CURRENT);
        push_rs(32'd5);
        push_rs(32'h80000000);
        // Current entry rewritten to state three: not handed back
        push_wr(4'd15, 16'd7, ST_SPARE);
        push_rs(32'd1);
        push_wr(4'd9, 16'hFFFF, ST_READY);
        push_wr(4'd12, 16'h8000, ST_READY);
        push_rs(32'h0000FFFF);
        push_rs(32'h0000FFFE);
        push_rs('1);
        drain();

        // Random phases; each ends by draining, so the sender waits for
        // every outstanding draw before the pacing changes
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = pace[p];
            cnt = 0;
            while (cnt < PHASE_BEATS)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                begin
                    // Fill every entry with maximum tickets, then draw
                    for (int k = 0; k < NPROC; k++)
                        push_wr(IDX_IN_W'(k), 16'hFFFF, ST_READY);
                    push_rs(rand_draw());
                    cnt += NPROC + 1;
                end
                else if (r < 4)
                begin
                    // Empty the pool, then draw: no winner
                    for (int k = 0; k < NPROC; k++)
                        push_wr(IDX_IN_W'(k), rand_tickets(),
                                ($urandom_range(0, 1) != 0) ? ST_OTHER : ST_SPARE);
                    push_rs(rand_draw());
                    cnt += NPROC + 1;
                end
                else if (r < 34)
                begin
                    push_rs(rand_draw());
                    cnt++;
                end
                else
                begin
                    push_wr(IDX_IN_W'($urandom), rand_tickets(), rand_state());
                    cnt++;
                end
            end
            drain();
        end

        // Let any stray result show up before closing
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d command beats in 4 pacing phases: %0d draws, %0d with no winner",
                 n_beats, n_draws, n_nowin);
        $display("%0d mismatches, %0d draws never returned", n_err, draw_q.size());
        if (n_err == 0 && draw_q.size() == 0)
            $display("lottery_scheduler_unit test passed");
        else
            $display("lottery_scheduler_unit test failed");
        $finish;
    end

endmodule
